// File: hw/rtl/mali_pkg.sv
// ----------------------------------------------------------------------------
// Multi-axis linear interpolator package
// Shared widths, register codes, word types and controller/datapath types.
// ----------------------------------------------------------------------------
`default_nettype none

package mali_pkg;

	localparam int AXIS_FIELDS = 6;
	localparam int COORD_W     = 32;
	localparam int MAG_W       = 32;
	localparam int RATE_W      = 10;
	localparam int NUM_W       = MAG_W + RATE_W;
	localparam int REM_W       = NUM_W + 1;
	localparam int FRAC_BITS   = 24;
	localparam int F_W         = FRAC_BITS + 1;
	localparam int PROD_W      = MAG_W + F_W;
	localparam int STEP_W      = 6;
	localparam int DIVS_ITERS  = STEP_W;
	localparam int DIVF_ITERS  = F_W;
	localparam int CNT_W       = 5;
	localparam int IDX_W       = 3;
	localparam int MODE_W      = 3;
	localparam int AXES_W      = 3;
	localparam int VLIM_W      = 32;
	localparam int NUM_VLIM    = 5;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;

	// Motion mode codes.
	localparam logic [MODE_W-1:0] MODE_ROBOT       = 3'd0;
	localparam logic [MODE_W-1:0] MODE_LIFT_ROTATE = 3'd1;
	localparam logic [MODE_W-1:0] MODE_LIFT_UP     = 3'd2;
	localparam logic [MODE_W-1:0] MODE_RAIL        = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CAR         = 3'd4;
	localparam logic [MODE_W-1:0] MODE_NONE        = 3'd5;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AXES        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VLIM_ROBOT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VLIM_ROTATE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VLIM_LIFT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_VLIM_RAIL   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_VLIM_CAR    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_RATE        = 3'd7;

	// Reset values of the configuration registers.
	localparam logic [MODE_W-1:0] RST_MODE       = MODE_NONE;
	localparam logic [AXES_W-1:0] RST_AXES       = 3'd6;
	localparam logic [VLIM_W-1:0] RST_VLIM_FAST  = 32'd327680;
	localparam logic [VLIM_W-1:0] RST_VLIM_SLOW  = 32'd6554;
	localparam logic [RATE_W-1:0] RST_RATE       = 10'd25;

	typedef struct packed {
		logic                      start_of_path;
		logic signed [COORD_W-1:0] axis0_target;
		logic signed [COORD_W-1:0] axis1_target;
		logic signed [COORD_W-1:0] axis2_target;
		logic signed [COORD_W-1:0] axis3_target;
		logic signed [COORD_W-1:0] axis4_target;
		logic signed [COORD_W-1:0] axis5_target;
	} waypoint_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] axis0_point;
		logic signed [COORD_W-1:0] axis1_point;
		logic signed [COORD_W-1:0] axis2_point;
		logic signed [COORD_W-1:0] axis3_point;
		logic signed [COORD_W-1:0] axis4_point;
		logic signed [COORD_W-1:0] axis5_point;
		logic                      segment_end;
	} point_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MAXS,
		ST_NUM,
		ST_CHK,
		ST_DIVS,
		ST_DCHK,
		ST_DIVF,
		ST_FSET,
		ST_STEP,
		ST_MUL,
		ST_ADD,
		ST_EMIT,
		ST_ENDP,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic             capture;
		logic             load;
		logic             max_step;
		logic             num_calc;
		logic             sat_load;
		logic             divs_load;
		logic             divf_load;
		logic             div_step;
		logic             f_set;
		logic             f_step;
		logic             mul;
		logic             add;
		logic             show_end;
		logic             fin;
		logic [IDX_W-1:0] idx;
	} ctrl_cmd_t;

	typedef struct packed {
		logic             skip;
		logic             num_zero;
		logic             sat_pre;
		logic             quo_over;
		logic             quo_zero;
		logic             k_last;
		logic [IDX_W-1:0] last_axis;
	} dp_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/mali_datapath.sv
// ----------------------------------------------------------------------------
// Interpolator datapath
// Configuration, waypoint storage, shared divider, fraction stepper and the
// shared multiplier that forms each axis of the interpolated points.
// ----------------------------------------------------------------------------
`default_nettype none

module mali_datapath import mali_pkg::*; #(
	parameter int NUM_AXES  = 6,
	parameter int MAX_STEPS = 63
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire waypoint_t             waypoint,
	input  wire ctrl_cmd_t             cmd,
	output dp_status_t                 status,
	output point_t                     point
);

	localparam int AXIS_LIMIT = (NUM_AXES < AXIS_FIELDS) ? NUM_AXES : AXIS_FIELDS;
	localparam logic [IDX_W-1:0] LIMIT_N   = IDX_W'(AXIS_LIMIT);
	localparam logic [F_W-1:0]   SAT_Q0    = F_W'((1 << FRAC_BITS) / MAX_STEPS);
	localparam logic [NUM_W-1:0] SAT_R0    = NUM_W'((1 << FRAC_BITS) % MAX_STEPS);
	localparam logic [NUM_W-1:0] SAT_DEN   = NUM_W'(MAX_STEPS);
	localparam logic [STEP_W-1:0] SAT_STEPS = STEP_W'(MAX_STEPS);

	logic [MODE_W-1:0] mode_q;
	logic [AXES_W-1:0] axes_q;
	logic [VLIM_W-1:0] vlim_q [NUM_VLIM];
	logic [RATE_W-1:0] rate_q;

	logic [COORD_W-1:0] prev_q [AXIS_FIELDS];
	logic [COORD_W-1:0] tgt_q  [AXIS_FIELDS];
	logic [MAG_W-1:0]   mag_q  [AXIS_FIELDS];
	logic               neg_q  [AXIS_FIELDS];
	logic [COORD_W-1:0] pt_q   [AXIS_FIELDS];
	logic               have_prev_q;
	logic               start_q;

	logic [MAG_W-1:0]  dmax_q;
	logic [NUM_W-1:0]  num_q;
	logic [REM_W-1:0]  rem_q;
	logic [NUM_W-1:0]  div_q;
	logic [F_W-1:0]    dsh_q;
	logic [F_W-1:0]    quo_q;
	logic [F_W-1:0]    q0_q;
	logic [NUM_W-1:0]  r0_q;
	logic [NUM_W-1:0]  den_q;
	logic [STEP_W-1:0] steps_q;
	logic [STEP_W-1:0] k_q;
	logic [F_W-1:0]    facc_q;
	logic [NUM_W-1:0]  frem_q;
	logic [PROD_W-1:0] prod_s1;

	logic [COORD_W-1:0] in_axis [AXIS_FIELDS];
	logic [IDX_W-1:0]   n_eff;
	logic [IDX_W-1:0]   searched;
	logic [VLIM_W-1:0]  vlim_sel;
	logic [REM_W-1:0]   div_trial;
	logic               div_fit;
	logic [REM_W-1:0]   fsum;
	logic               fwrap;
	logic [MAG_W-1:0]   offset;
	logic [COORD_W:0]   pos_sum;
	logic [COORD_W-1:0] out_axis [AXIS_FIELDS];

	assign in_axis[0] = waypoint.axis0_target;
	assign in_axis[1] = waypoint.axis1_target;
	assign in_axis[2] = waypoint.axis2_target;
	assign in_axis[3] = waypoint.axis3_target;
	assign in_axis[4] = waypoint.axis4_target;
	assign in_axis[5] = waypoint.axis5_target;

	// Effective axis count: zero acts as one, large values clamp to the limit.
	always_comb begin
		if (axes_q == '0) begin
			n_eff = IDX_W'(1);
		end else if (axes_q > LIMIT_N) begin
			n_eff = LIMIT_N;
		end else begin
			n_eff = axes_q;
		end
		searched = (mode_q == MODE_CAR) ? n_eff - IDX_W'(1) : n_eff;
	end

	always_comb begin
		unique case (mode_q)
			MODE_ROBOT:       vlim_sel = vlim_q[0];
			MODE_LIFT_ROTATE: vlim_sel = vlim_q[1];
			MODE_LIFT_UP:     vlim_sel = vlim_q[2];
			MODE_RAIL:        vlim_sel = vlim_q[3];
			MODE_CAR:         vlim_sel = vlim_q[4];
			default:          vlim_sel = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= RST_MODE;
			axes_q    <= RST_AXES;
			vlim_q[0] <= RST_VLIM_FAST;
			vlim_q[1] <= RST_VLIM_FAST;
			vlim_q[2] <= RST_VLIM_SLOW;
			vlim_q[3] <= RST_VLIM_SLOW;
			vlim_q[4] <= RST_VLIM_SLOW;
			rate_q    <= RST_RATE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:        mode_q    <= cfg_data[MODE_W-1:0];
				REG_AXES:        axes_q    <= cfg_data[AXES_W-1:0];
				REG_VLIM_ROBOT:  vlim_q[0] <= cfg_data;
				REG_VLIM_ROTATE: vlim_q[1] <= cfg_data;
				REG_VLIM_LIFT:   vlim_q[2] <= cfg_data;
				REG_VLIM_RAIL:   vlim_q[3] <= cfg_data;
				REG_VLIM_CAR:    vlim_q[4] <= cfg_data;
				REG_RATE:        rate_q    <= cfg_data[RATE_W-1:0];
				default:         rate_q    <= rate_q;
			endcase
		end
	end

	// Previous waypoint and its flag are architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			for (int j = 0; j < AXIS_FIELDS; j++) begin
				prev_q[j] <= '0;
			end
		end else if (cmd.fin) begin
			have_prev_q <= 1'b1;
			for (int j = 0; j < AXIS_FIELDS; j++) begin
				prev_q[j] <= tgt_q[j];
			end
		end
	end

	// Shared restoring divider step: one quotient bit per cycle. Also the fraction carry and the axis position sum.
	always_comb begin
		div_trial = {rem_q[REM_W-2:0], dsh_q[F_W-1]};
		div_fit   = div_trial >= {1'b0, div_q};
		fsum      = {1'b0, frem_q} + {1'b0, r0_q};
		fwrap     = fsum >= {1'b0, den_q};
		offset    = prod_s1[FRAC_BITS +: MAG_W];
		if (neg_q[cmd.idx]) begin
			pos_sum = {prev_q[cmd.idx][COORD_W-1], prev_q[cmd.idx]} - {1'b0, offset};
		end else begin
			pos_sum = {prev_q[cmd.idx][COORD_W-1], prev_q[cmd.idx]} + {1'b0, offset};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			start_q <= waypoint.start_of_path;
			for (int j = 0; j < AXIS_FIELDS; j++) begin
				tgt_q[j] <= in_axis[j];
			end
		end
		if (cmd.load) begin
			dmax_q <= '0;
			for (int j = 0; j < AXIS_FIELDS; j++) begin
				logic [COORD_W:0] diff;
				diff     = {tgt_q[j][COORD_W-1], tgt_q[j]} - {prev_q[j][COORD_W-1], prev_q[j]};
				neg_q[j] <= diff[COORD_W];
				mag_q[j] <= diff[COORD_W] ? MAG_W'(-diff) : MAG_W'(diff);
			end
		end
		if (cmd.max_step && (cmd.idx < searched) && (mag_q[cmd.idx] > dmax_q)) begin
			dmax_q <= mag_q[cmd.idx];
		end
		if (cmd.num_calc) begin
			num_q <= dmax_q * rate_q;
		end
		if (cmd.divs_load) begin
			rem_q <= REM_W'(num_q >> DIVS_ITERS);
			div_q <= NUM_W'(vlim_sel);
			dsh_q <= {num_q[DIVS_ITERS-1:0], {(F_W-DIVS_ITERS){1'b0}}};
			quo_q <= '0;
		end else if (cmd.divf_load) begin
			rem_q   <= REM_W'(vlim_sel >> 1);
			div_q   <= num_q;
			dsh_q   <= {vlim_sel[0], {(F_W-1){1'b0}}};
			quo_q   <= '0;
			steps_q <= quo_q[STEP_W-1:0];
		end else if (cmd.div_step) begin
			rem_q <= div_fit ? div_trial - {1'b0, div_q} : div_trial;
			dsh_q <= {dsh_q[F_W-2:0], 1'b0};
			quo_q <= {quo_q[F_W-2:0], div_fit};
		end
		if (cmd.sat_load) begin
			q0_q    <= SAT_Q0;
			r0_q    <= SAT_R0;
			den_q   <= SAT_DEN;
			steps_q <= SAT_STEPS;
			facc_q  <= '0;
			frem_q  <= '0;
			k_q     <= '0;
		end else if (cmd.f_set) begin
			q0_q   <= quo_q;
			r0_q   <= rem_q[NUM_W-1:0];
			den_q  <= num_q;
			facc_q <= '0;
			frem_q <= '0;
			k_q    <= '0;
		end else if (cmd.f_step) begin
			k_q    <= k_q + STEP_W'(1);
			facc_q <= facc_q + q0_q + F_W'(fwrap);
			frem_q <= fwrap ? NUM_W'(fsum - {1'b0, den_q}) : fsum[NUM_W-1:0];
		end
		if (cmd.mul) begin
			prod_s1 <= mag_q[cmd.idx] * facc_q;
		end
		if (cmd.add) begin
			pt_q[cmd.idx] <= pos_sum[COORD_W-1:0];
		end
	end

	always_comb begin
		status.skip      = start_q | ~have_prev_q | (mode_q > MODE_CAR);
		status.num_zero  = num_q == '0;
		status.sat_pre   = (vlim_sel == '0) ||
		                   (num_q >= NUM_W'({vlim_sel, {DIVS_ITERS{1'b0}}}));
		status.quo_over  = quo_q[STEP_W-1:0] > SAT_STEPS;
		status.quo_zero  = quo_q[STEP_W-1:0] == '0;
		status.k_last    = k_q == steps_q;
		status.last_axis = n_eff - IDX_W'(1);
	end

	always_comb begin
		for (int j = 0; j < AXIS_FIELDS; j++) begin
			if (IDX_W'(j) < n_eff) begin
				out_axis[j] = cmd.show_end ? tgt_q[j] : pt_q[j];
			end else begin
				out_axis[j] = '0;
			end
		end
		point.axis0_point = out_axis[0];
		point.axis1_point = out_axis[1];
		point.axis2_point = out_axis[2];
		point.axis3_point = out_axis[3];
		point.axis4_point = out_axis[4];
		point.axis5_point = out_axis[5];
		point.segment_end = cmd.show_end;
	end

endmodule

`default_nettype wire

// File: hw/rtl/mali_controller.sv
// ----------------------------------------------------------------------------
// Interpolator controller
// Sequences one waypoint through search, division and point generation and
// runs both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module mali_controller import mali_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       waypoint_valid,
	output logic            waypoint_stall,
	output logic            point_valid,
	input  wire logic       point_stall,
	input  wire dp_status_t status,
	output ctrl_cmd_t       cmd
);

	localparam logic [IDX_W-1:0] LAST_FIELD = IDX_W'(AXIS_FIELDS - 1);
	localparam logic [CNT_W-1:0] DIVS_LAST  = CNT_W'(DIVS_ITERS - 1);
	localparam logic [CNT_W-1:0] DIVF_LAST  = CNT_W'(DIVF_ITERS - 1);

	state_t            state_q;
	state_t            state_d;
	logic [IDX_W-1:0]  idx_q;
	logic [CNT_W-1:0]  cnt_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (waypoint_valid) state_d = ST_LOAD;
			ST_LOAD: state_d = status.skip ? ST_FIN : ST_MAXS;
			ST_MAXS: if (idx_q == LAST_FIELD) state_d = ST_NUM;
			ST_NUM:  state_d = ST_CHK;
			ST_CHK: begin
				if (status.num_zero) begin
					state_d = ST_ENDP;
				end else if (status.sat_pre) begin
					state_d = ST_STEP;
				end else begin
					state_d = ST_DIVS;
				end
			end
			ST_DIVS: if (cnt_q == DIVS_LAST) state_d = ST_DCHK;
			ST_DCHK: begin
				if (status.quo_over) begin
					state_d = ST_STEP;
				end else if (status.quo_zero) begin
					state_d = ST_ENDP;
				end else begin
					state_d = ST_DIVF;
				end
			end
			ST_DIVF: if (cnt_q == DIVF_LAST) state_d = ST_FSET;
			ST_FSET: state_d = ST_STEP;
			ST_STEP: state_d = ST_MUL;
			ST_MUL:  state_d = ST_ADD;
			ST_ADD:  state_d = (idx_q == status.last_axis) ? ST_EMIT : ST_MUL;
			ST_EMIT: if (!point_stall) state_d = status.k_last ? ST_ENDP : ST_STEP;
			ST_ENDP: if (!point_stall) state_d = ST_FIN;
			ST_FIN:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.idx        = idx_q;
		waypoint_stall = state_q != ST_IDLE;
		point_valid    = 1'b0;
		unique case (state_q)
			ST_IDLE: cmd.capture = waypoint_valid;
			ST_LOAD: cmd.load = 1'b1;
			ST_MAXS: cmd.max_step = 1'b1;
			ST_NUM:  cmd.num_calc = 1'b1;
			ST_CHK: begin
				cmd.sat_load  = ~status.num_zero & status.sat_pre;
				cmd.divs_load = ~status.num_zero & ~status.sat_pre;
			end
			ST_DIVS: cmd.div_step = 1'b1;
			ST_DCHK: begin
				cmd.sat_load  = status.quo_over;
				cmd.divf_load = ~status.quo_over & ~status.quo_zero;
			end
			ST_DIVF: cmd.div_step = 1'b1;
			ST_FSET: cmd.f_set = 1'b1;
			ST_STEP: cmd.f_step = 1'b1;
			ST_MUL:  cmd.mul = 1'b1;
			ST_ADD:  cmd.add = 1'b1;
			ST_EMIT: point_valid = 1'b1;
			ST_ENDP: begin
				point_valid  = 1'b1;
				cmd.show_end = 1'b1;
			end
			ST_FIN:  cmd.fin = 1'b1;
			default: cmd.fin = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_LOAD || state_q == ST_STEP) begin
				idx_q <= '0;
			end else if (state_q == ST_MAXS || state_q == ST_ADD) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (state_q == ST_CHK || state_q == ST_DCHK) begin
				cnt_q <= '0;
			end else if (state_q == ST_DIVS || state_q == ST_DIVF) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/multi_axis_linear_interpolator_top.sv
// Flow: a waypoint that emits nothing is only stored; a zero move yields only its endpoint
// word; a full segment runs both divides (neither when saturation shows at once) and then S
// point words, S the step count (at most MAX_STEPS). One waypoint at a time: the next is
// taken once the endpoint word has left and the finish state has stored the waypoint. The
// bit-serial fraction divide and the shared multiplier set the pace. Async reset, low.
// ----------------------------------------------------------------------------
// Multi-axis linear interpolator, top level
// Turns waypoints into velocity-limited, linearly interpolated point words.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_axis_linear_interpolator_top import mali_pkg::*; #(
	parameter int NUM_AXES  = 6,
	parameter int MAX_STEPS = 63
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  waypoint_valid,
	output logic                       waypoint_stall,
	input  wire waypoint_t             waypoint,
	output logic                       point_valid,
	input  wire logic                  point_stall,
	output point_t                     point
);

	// The controller walks each waypoint through these phases: load the moves,
	// search the largest one, scale it by the trajectory rate, divide by the
	// velocity limit for the step count, divide once more for the per-step
	// fraction, then step the fraction and form each axis with the multiplier.
	// The fraction advances by a quotient plus a carried remainder, so no
	// division is needed per point.

	ctrl_cmd_t  cmd;
	dp_status_t status;

	mali_controller u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.waypoint_valid (waypoint_valid),
		.waypoint_stall (waypoint_stall),
		.point_valid    (point_valid),
		.point_stall    (point_stall),
		.status         (status),
		.cmd            (cmd)
	);

	mali_datapath #(
		.NUM_AXES  (NUM_AXES),
		.MAX_STEPS (MAX_STEPS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.waypoint  (waypoint),
		.cmd       (cmd),
		.status    (status),
		.point     (point)
	);

	// A point word is never offered while a new waypoint could be taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		point_valid |-> waypoint_stall)
		else $error("point word offered while waypoint port is open");

	// Once a waypoint is taken the block stays busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(waypoint_valid && !waypoint_stall) |=> waypoint_stall)
		else $error("waypoint port open right after a waypoint was taken");

	// The endpoint word closes the segment: nothing follows it directly.
	assert property (@(posedge clk) disable iff (!arst_n)
		(point_valid && !point_stall && point.segment_end) |=> !point_valid)
		else $error("point word follows the segment endpoint");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Interpolator testbench
// Drives waypoints through several register settings and checks every point
// word against a built-in predictor of the velocity-limited interpolation.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top import mali_pkg::*; ();

	localparam int MAX_STEPS   = 63;
	localparam int CYCLE_LIMIT = 2000000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  waypoint_valid;
	logic                  waypoint_stall;
	waypoint_t             waypoint;
	logic                  point_valid;
	logic                  point_stall;
	point_t                point;

	multi_axis_linear_interpolator_top #(
		.NUM_AXES (6),
		.MAX_STEPS(MAX_STEPS)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.waypoint_valid(waypoint_valid),
		.waypoint_stall(waypoint_stall),
		.waypoint      (waypoint),
		.point_valid   (point_valid),
		.point_stall   (point_stall),
		.point         (point)
	);

	// Shadow copy of the block's registers and its stored waypoint.
	logic [MODE_W-1:0] mode_q;
	logic [AXES_W-1:0] axes_q;
	logic [31:0]       vlim_q [NUM_VLIM];
	logic [RATE_W-1:0] rate_q;
	logic [31:0]       last_wp [AXIS_FIELDS];
	bit                have_wp;

	waypoint_t pending_waypoints[$];
	point_t    expected_points[$];

	int  mismatch_count;
	int  cycle_count;
	int  send_idle_pct;
	int  recv_idle_pct;
	bit  wp_taken;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Any check failure goes through here: one line per problem.
	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("MISMATCH at cycle %0d: %s", cycle_count, what);
	endtask

	function automatic void reset_shadow();
		mode_q    = RST_MODE;
		axes_q    = RST_AXES;
		vlim_q[0] = RST_VLIM_FAST;
		vlim_q[1] = RST_VLIM_FAST;
		vlim_q[2] = RST_VLIM_SLOW;
		vlim_q[3] = RST_VLIM_SLOW;
		vlim_q[4] = RST_VLIM_SLOW;
		rate_q    = RST_RATE;
		foreach (last_wp[j]) last_wp[j] = '0;
		have_wp = 1'b0;
	endfunction

	function automatic point_t pack_point(input logic signed [63:0] pos [AXIS_FIELDS],
			input int n, input bit last);
		logic [31:0] f [AXIS_FIELDS];
		point_t      p;
		for (int j = 0; j < AXIS_FIELDS; j++) f[j] = (j < n) ? pos[j][31:0] : 32'd0;
		p.axis0_point = f[0];
		p.axis1_point = f[1];
		p.axis2_point = f[2];
		p.axis3_point = f[3];
		p.axis4_point = f[4];
		p.axis5_point = f[5];
		p.segment_end = last;
		return p;
	endfunction

	// Interpolates one accepted waypoint and queues the point words it yields.
	function automatic void interpolate_waypoint(input waypoint_t w);
		logic signed [63:0] prev [AXIS_FIELDS];
		logic signed [63:0] tgt  [AXIS_FIELDS];
		logic signed [63:0] move [AXIS_FIELDS];
		logic signed [63:0] pos  [AXIS_FIELDS];
		logic [63:0]        mag  [AXIS_FIELDS];
		logic [31:0]        raw  [AXIS_FIELDS];
		logic [63:0]        dmax, vlim, num, steps, frac, off;
		int                 n, searched;
		bit                 was, sat;
		raw[0] = w.axis0_target;
		raw[1] = w.axis1_target;
		raw[2] = w.axis2_target;
		raw[3] = w.axis3_target;
		raw[4] = w.axis4_target;
		raw[5] = w.axis5_target;
		n = axes_q;
		if (n < 1) n = 1;
		if (n > AXIS_FIELDS) n = AXIS_FIELDS;
		for (int j = 0; j < AXIS_FIELDS; j++) begin
			prev[j] = {{32{last_wp[j][31]}}, last_wp[j]};
			tgt[j]  = {{32{raw[j][31]}}, raw[j]};
			move[j] = tgt[j] - prev[j];
			mag[j]  = (move[j] < 0) ? -move[j] : move[j];
			last_wp[j] = raw[j];
		end
		was = have_wp;
		have_wp = 1'b1;
		if (w.start_of_path || !was || mode_q > MODE_CAR) return;

		// Car mode leaves its last axis out of the speed search.
		searched = (mode_q == MODE_CAR) ? n - 1 : n;
		dmax = 0;
		for (int j = 0; j < searched; j++) if (mag[j] > dmax) dmax = mag[j];
		vlim  = vlim_q[mode_q];
		num   = dmax * rate_q;
		steps = 0;
		sat   = 1'b0;
		if (num != 0) begin
			if (vlim == 0 || num / vlim > MAX_STEPS) begin
				steps = MAX_STEPS;
				sat   = 1'b1;
			end else begin
				steps = num / vlim;
			end
		end
		for (longint k = 1; k <= steps; k++) begin
			if (sat) frac = (64'(k) << FRAC_BITS) / MAX_STEPS;
			else     frac = ((64'(k) * vlim) << FRAC_BITS) / num;
			for (int j = 0; j < n; j++) begin
				off    = (mag[j] * frac) >> FRAC_BITS;
				pos[j] = (move[j] < 0) ? prev[j] - off : prev[j] + off;
			end
			for (int j = n; j < AXIS_FIELDS; j++) pos[j] = 0;
			expected_points = {expected_points, pack_point(pos, n, 1'b0)};
		end
		expected_points = {expected_points, pack_point(tgt, n, 1'b1)};
	endfunction

	// Driver: offers the oldest pending word, holds it until it is taken, and drives random output stalls.
	always @(negedge clk) begin
		if (!arst_n) begin
			waypoint_valid <= 1'b0;
			waypoint       <= '0;
			point_stall    <= 1'b0;
		end else begin
			if (!waypoint_valid || wp_taken) begin
				if (pending_waypoints.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					waypoint       <= pending_waypoints.pop_front();
					waypoint_valid <= 1'b1;
				end else begin
					waypoint_valid <= 1'b0;
				end
			end
			point_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Monitor: predicts on accepted waypoints, checks accepted points.
	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count <= cycle_count + 1;
			wp_taken    <= waypoint_valid && !waypoint_stall;
			if (waypoint_valid && !waypoint_stall) interpolate_waypoint(waypoint);
			if (point_valid && !point_stall) begin
				if (expected_points.size() == 0) begin
					report_mismatch("point word with nothing expected");
				end else begin
					point_t e;
					e = expected_points.pop_front();
					if (point.axis0_point !== e.axis0_point) report_mismatch("axis0_point");
					if (point.axis1_point !== e.axis1_point) report_mismatch("axis1_point");
					if (point.axis2_point !== e.axis2_point) report_mismatch("axis2_point");
					if (point.axis3_point !== e.axis3_point) report_mismatch("axis3_point");
					if (point.axis4_point !== e.axis4_point) report_mismatch("axis4_point");
					if (point.axis5_point !== e.axis5_point) report_mismatch("axis5_point");
					if (point.segment_end !== e.segment_end) report_mismatch("segment_end");
				end
			end
		end
	end

	// Timeout watchdog.
	always @(posedge clk) begin
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Some tests failed");
			$finish;
		end
	end

	// Callers must write registers only while the block is idle (not enforced here); the shadow follows.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MODE: mode_q = val[MODE_W-1:0];
			REG_AXES: axes_q = val[AXES_W-1:0];
			REG_RATE: rate_q = val[RATE_W-1:0];
			default: vlim_q[idx - REG_VLIM_ROBOT] = val;
		endcase
	endtask

	// Waits until every queued word is taken and every point has come back,
	// then leaves room for a waypoint that yields nothing to finish.
	task automatic drain();
		while (pending_waypoints.size() > 0 || waypoint_valid || expected_points.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic waypoint_t make_waypoint(input bit sop, input logic [31:0] a0,
			input logic [31:0] a1, input logic [31:0] a2, input logic [31:0] a3,
			input logic [31:0] a4, input logic [31:0] a5);
		waypoint_t w;
		w.start_of_path = sop;
		w.axis0_target = a0;
		w.axis1_target = a1;
		w.axis2_target = a2;
		w.axis3_target = a3;
		w.axis4_target = a4;
		w.axis5_target = a5;
		return w;
	endfunction

	task automatic queue_waypoint(input waypoint_t w);
		pending_waypoints = {pending_waypoints, w};
	endtask

	// Random coordinate: mostly a small step from a base, sometimes the base itself or anything,
	// so segments have modest step counts but every bit still toggles.
	function automatic logic [31:0] rand_coord(input logic [31:0] base);
		case ($urandom_range(3))
			0: return $urandom;
			1: return base;
			default: return base + $signed($urandom_range(400000)) - 200000;
		endcase
	endfunction

	task automatic queue_path(input int len);
		logic [31:0] b [AXIS_FIELDS];
		foreach (b[j]) b[j] = $urandom;
		for (int i = 0; i < len; i++) begin
			foreach (b[j]) b[j] = rand_coord(b[j]);
			queue_waypoint(make_waypoint(i == 0 || $urandom_range(15) == 0,
				b[0], b[1], b[2], b[3], b[4], b[5]));
		end
	endtask

	// One random phase: a fresh register setting, then a few paths.
	task automatic random_phase(input int items);
		int mode_pick;
		mode_pick = $urandom_range(7);
		write_reg(REG_MODE, 32'(mode_pick > 5 ? $urandom_range(4) : mode_pick));
		write_reg(REG_AXES, $urandom_range(7));
		write_reg(CFG_IDX_W'(REG_VLIM_ROBOT + $urandom_range(4)), $urandom_range(1, 20000));
		write_reg(REG_RATE, $urandom_range(1, 60));
		while (items > 0) begin
			queue_path(5);
			items -= 5;
		end
		drain();
	endtask

	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		send_idle_pct  = 25;
		recv_idle_pct  = 66;
		reset_shadow();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: mode none stores only, then robot mode with extremes.
		queue_waypoint(make_waypoint(1'b0, 32'h7fffffff, 32'h80000000,
			32'h1, 32'hffffffff, 32'h0, 32'h12345678));
		queue_waypoint(make_waypoint(1'b0, 32'h0, 32'h0, 32'h0, 32'h0,
			32'h0, 32'h0));
		drain();
		write_reg(REG_MODE, 32'(MODE_ROBOT));
		write_reg(REG_VLIM_ROBOT, 32'd65536);
		write_reg(REG_RATE, 32'd10);
		queue_waypoint(make_waypoint(1'b1, 32'h0, 32'h0, 32'h0, 32'h0,
			32'h0, 32'h0));
		// Short move, zero move, full-range move that saturates, negative move.
		queue_waypoint(make_waypoint(1'b0, 32'h50000, 32'hfffb0000,
			32'h1, 32'h0, 32'h30000, 32'hffffffff));
		queue_waypoint(make_waypoint(1'b0, 32'h50000, 32'hfffb0000,
			32'h1, 32'h0, 32'h30000, 32'hffffffff));
		queue_waypoint(make_waypoint(1'b0, 32'h80000000, 32'h7fffffff,
			32'h80000000, 32'h7fffffff, 32'h0, 32'h1));
		queue_waypoint(make_waypoint(1'b0, 32'h7fffffff, 32'h80000000,
			32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h0));
		drain();
		// Zero velocity limit saturates; zero rate gives the endpoint only.
		write_reg(REG_VLIM_ROBOT, 32'd0);
		queue_waypoint(make_waypoint(1'b0, 32'h100, 32'h0, 32'h0, 32'h0,
			32'h0, 32'h0));
		drain();
		write_reg(REG_VLIM_ROBOT, 32'hffffffff);
		write_reg(REG_RATE, 32'd1000);
		queue_waypoint(make_waypoint(1'b0, 32'h7fffffff, 32'h5, 32'h0,
			32'h0, 32'h0, 32'h0));
		drain();
		write_reg(REG_RATE, 32'd0);
		queue_waypoint(make_waypoint(1'b0, 32'h0, 32'h0, 32'h0, 32'h0,
			32'h0, 32'h0));
		drain();
		// Every other mode, with out-of-range axis counts and the car case n = 1.
		write_reg(REG_RATE, 32'd1);
		write_reg(REG_VLIM_ROTATE, 32'd1);
		write_reg(REG_VLIM_LIFT, 32'd40000);
		write_reg(REG_VLIM_RAIL, 32'd100000);
		write_reg(REG_VLIM_CAR, 32'd70000);
		for (int m = MODE_LIFT_ROTATE; m <= MODE_CAR; m++) begin
			write_reg(REG_MODE, 32'(m));
			write_reg(REG_AXES, (m == MODE_CAR) ? 32'd1 : 32'd7);
			queue_waypoint(make_waypoint(1'b0, 32'h20000, 32'hfffe0000,
				32'h1000, 32'h0, 32'h5000, 32'h10000));
			queue_waypoint(make_waypoint(1'b0, 32'h0, 32'h0, 32'h0, 32'h0,
				32'h0, 32'h0));
			drain();
		end
		write_reg(REG_AXES, 32'd0);
		write_reg(REG_MODE, 32'd7);
		queue_waypoint(make_waypoint(1'b0, 32'h1, 32'h2, 32'h3, 32'h4,
			32'h5, 32'h6));
		drain();

		// Random phases under the three idling patterns.
		for (int phase = 0; phase < 6; phase++) begin
			if (phase == 2) begin
				send_idle_pct = 66;
				recv_idle_pct = 25;
			end else if (phase == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			random_phase(15);
		end

		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
